// ===== src/plids_pkg.sv =====
// shared types and constants for the positional list core
package plids_pkg;

  // list geometry
  localparam int unsigned DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // field widths on the stream ports
  localparam int unsigned CMD_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 5;
  localparam int unsigned OIDX_W = 5;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // width used to compare a position against the count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_SEARCH  = 3'd4,
    CMD_DISPLAY = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DISP
  } state_e;

  // which kind of result the datapath loads into its output register
  typedef enum logic [2:0] {
    RES_OK,
    RES_FULL,
    RES_RANGE,
    RES_MISS,
    RES_FOUND,
    RES_ENTRY
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     s_ready;
    logic     do_clear;
    logic     do_append;
    logic     do_insert;
    logic     do_delete;
    logic     key_load;
    logic     idx_clr;
    logic     idx_inc;
    logic     emit;
    res_sel_e res_sel;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic full;
    logic ins_ok;
    logic del_ok;
    logic count_zero;
    logic idx_end;
    logic hit;
    logic disp_last;
  } sts_t;

endpackage

// ===== src/plids_ctrl.sv =====
// command sequencer for the positional list core
module plids_ctrl
  import plids_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  sts_t             sts_i,
  output ctl_t             ctl_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE) && sts_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_SEARCH) begin
            state_d = ST_SEARCH;
          end else if (cmd_i == CMD_DISPLAY && !sts_i.count_zero) begin
            state_d = ST_DISP;
          end
        end
      end
      ST_SEARCH: begin
        if (sts_i.out_free && (sts_i.idx_end || sts_i.hit)) begin
          state_d = ST_IDLE;
        end
      end
      ST_DISP: begin
        if (sts_i.out_free && sts_i.disp_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl_o         = '0;
    ctl_o.res_sel = RES_OK;
    case (state_q)
      ST_IDLE: begin
        ctl_o.s_ready = sts_i.out_free;
        if (accept) begin
          case (cmd_i)
            CMD_CLEAR: begin
              ctl_o.do_clear = 1'b1;
              ctl_o.emit     = 1'b1;
            end
            CMD_APPEND: begin
              ctl_o.emit = 1'b1;
              if (sts_i.full) begin
                ctl_o.res_sel = RES_FULL;
              end else begin
                ctl_o.do_append = 1'b1;
              end
            end
            CMD_INSERT: begin
              ctl_o.emit = 1'b1;
              if (sts_i.full) begin
                ctl_o.res_sel = RES_FULL;
              end else if (!sts_i.ins_ok) begin
                ctl_o.res_sel = RES_RANGE;
              end else begin
                ctl_o.do_insert = 1'b1;
              end
            end
            CMD_DELETE: begin
              ctl_o.emit = 1'b1;
              if (!sts_i.del_ok) begin
                ctl_o.res_sel = RES_RANGE;
              end else begin
                ctl_o.do_delete = 1'b1;
              end
            end
            CMD_SEARCH: begin
              ctl_o.key_load = 1'b1;
              ctl_o.idx_clr  = 1'b1;
            end
            CMD_DISPLAY: begin
              if (sts_i.count_zero) begin
                ctl_o.emit = 1'b1;
              end else begin
                ctl_o.idx_clr = 1'b1;
              end
            end
            // unused codes give a plain ok result
            default: ctl_o.emit = 1'b1;
          endcase
        end
      end
      ST_SEARCH: begin
        if (sts_i.out_free) begin
          if (sts_i.idx_end) begin
            ctl_o.emit    = 1'b1;
            ctl_o.res_sel = RES_MISS;
          end else if (sts_i.hit) begin
            ctl_o.emit    = 1'b1;
            ctl_o.res_sel = RES_FOUND;
          end else begin
            ctl_o.idx_inc = 1'b1;
          end
        end
      end
      ST_DISP: begin
        if (sts_i.out_free) begin
          ctl_o.emit    = 1'b1;
          ctl_o.res_sel = RES_ENTRY;
          ctl_o.idx_inc = 1'b1;
        end
      end
      default: ctl_o = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // input is taken only between commands
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.s_ready |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  // at most one list update per cycle
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.do_clear, ctl_o.do_append, ctl_o.do_insert, ctl_o.do_delete}))
    else $error("several list updates at once");

  // a search that runs off the end finishes
  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && sts_i.out_free && sts_i.idx_end) |=> state_q == ST_IDLE)
    else $error("search did not finish at end of list");

endmodule

// ===== src/plids_dp.sv =====
// cell chain, count, scan index and output register of the positional list core
module plids_dp
  import plids_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  input  logic signed [VAL_W-1:0]  value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic                     out_ready_i,
  output sts_t                     sts_o,
  output logic                     out_valid_o,
  output logic signed [VAL_W-1:0]  out_entry_o,
  output logic [OIDX_W-1:0]        out_index_o,
  output logic [STAT_W-1:0]        out_status_o,
  output logic [LEN_W-1:0]         out_length_o,
  output logic                     out_last_o
);

  logic [VAL_W-1:0]        entries_q [DEPTH];
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [VAL_W-1:0]        key_q;
  logic [CMP_W-1:0]        pos_x, cnt_x;
  logic [VAL_W-1:0]        rd_entry;
  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_entry_q;
  logic [OIDX_W-1:0]       out_index_q;
  logic [STAT_W-1:0]       out_status_q;
  logic [LEN_W-1:0]        out_length_q;
  logic                    out_last_q;
  logic                    disp_last;

  assign pos_x = CMP_W'(position_i);
  assign cnt_x = CMP_W'(count_q);

  // list cells: each one takes itself, a neighbor or the new value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] CellIdx = CMP_W'(i);
    logic [VAL_W-1:0] below_w;
    logic [VAL_W-1:0] above_w;
    logic [VAL_W-1:0] cell_d;

    if (i == 0) begin : g_first
      assign below_w = value_i;
    end else begin : g_below
      assign below_w = entries_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign above_w = entries_q[i];
    end else begin : g_above
      assign above_w = entries_q[i+1];
    end

    always_comb begin
      cell_d = entries_q[i];
      if (ctl_i.do_append && CellIdx == cnt_x) begin
        cell_d = value_i;
      end else if (ctl_i.do_insert) begin
        if (CellIdx == pos_x) begin
          cell_d = value_i;
        end else if (CellIdx > pos_x && CellIdx <= cnt_x) begin
          cell_d = below_w;
        end
      end else if (ctl_i.do_delete) begin
        if (CellIdx >= pos_x && (CellIdx + 1'b1) < cnt_x) begin
          cell_d = above_w;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      entries_q[i] <= cell_d;
    end
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (ctl_i.do_clear) begin
      count_d = '0;
    end else if (ctl_i.do_append || ctl_i.do_insert) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.do_delete) begin
      count_d = count_q - 1'b1;
    end
  end

  // scan index shared by search and display
  always_comb begin
    idx_d = idx_q;
    if (ctl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctl_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // search key
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_load) begin
      key_q <= value_i;
    end
  end

  // one read port at the scan index
  assign rd_entry  = entries_q[idx_q[IDX_W-1:0]];
  assign disp_last = CNT_W'(idx_q + 1'b1) == count_q;

  // status to the controller
  always_comb begin
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.full       = count_q >= CNT_W'(DEPTH);
    sts_o.ins_ok     = pos_x <= cnt_x;
    sts_o.del_ok     = pos_x < cnt_x;
    sts_o.count_zero = count_q == '0;
    sts_o.idx_end    = idx_q >= count_q;
    sts_o.hit        = rd_entry == key_q;
    sts_o.disp_last  = disp_last;
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_entry_q  <= '0;
      out_index_q  <= '0;
      out_status_q <= STAT_OK;
      out_length_q <= LEN_W'(count_d);
      out_last_q   <= 1'b1;
      case (ctl_i.res_sel)
        RES_FULL:  out_status_q <= STAT_FULL;
        RES_RANGE: out_status_q <= STAT_RANGE;
        RES_MISS:  out_status_q <= STAT_MISSING;
        RES_FOUND: out_index_q  <= OIDX_W'(idx_q);
        RES_ENTRY: begin
          out_entry_q <= rd_entry;
          out_index_q <= OIDX_W'(idx_q);
          out_last_q  <= disp_last;
        end
        default: out_status_q <= STAT_OK;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_entry_o  = out_entry_q;
  assign out_index_o  = out_index_q;
  assign out_status_o = out_status_q;
  assign out_length_o = out_length_q;
  assign out_last_o   = out_last_q;

  // the count never passes the list size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above list size");

  // a result is never loaded over one still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> sts_o.out_free)
    else $error("result overwritten");

  // clear empties the list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.do_clear |=> count_q == '0)
    else $error("clear left entries");

endmodule

// ===== src/positional_list_insert_delete_search_core.sv =====
// top level of the positional list core with stream ports
// Keeps an ordered list of up to DEPTH signed 32-bit entries in a chain of
// registers and runs one command per input transfer: clear, append, insert,
// delete, search and display. Clear, append, insert, delete and unused codes
// finish in the cycle the command is taken, since every cell shifts at once
// from its neighbor, and give one result. Search walks the list through a
// single read port, one compare per cycle, and gives one result. Display
// sends one result per entry, one per cycle while the output is taken, with
// tlast on the final one; an empty list gives a single result. A new command
// is taken only once the previous one has finished and the output register
// is free or being drained in the same cycle.
module positional_list_insert_delete_search_core
  import plids_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // command [2:0], value [34:3], position [39:35]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // entry [31:0], index [36:32], status [38:37], length [44:39], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  ctl_t                    ctl;
  sts_t                    sts;
  logic [CMD_W-1:0]        in_cmd;
  logic signed [VAL_W-1:0] in_value;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] out_entry;
  logic [OIDX_W-1:0]       out_index;
  logic [STAT_W-1:0]       out_status;
  logic [LEN_W-1:0]        out_length;

  // unpack the input transfer
  assign in_cmd      = s_axis_tdata[CMD_W-1:0];
  assign in_value    = s_axis_tdata[CMD_W+VAL_W-1:CMD_W];
  assign in_position = s_axis_tdata[CMD_W+VAL_W+POS_W-1:CMD_W+VAL_W];

  plids_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .cmd_i      (in_cmd),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  plids_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .value_i      (in_value),
    .position_i   (in_position),
    .out_ready_i  (m_axis_tready),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_entry_o  (out_entry),
    .out_index_o  (out_index),
    .out_status_o (out_status),
    .out_length_o (out_length),
    .out_last_o   (m_axis_tlast)
  );

  assign s_axis_tready = ctl.s_ready;

  // pack the output transfer
  assign m_axis_tdata = {
    (OUT_DATA_W - VAL_W - OIDX_W - STAT_W - LEN_W)'(0),
    out_length, out_status, out_index, out_entry
  };

endmodule

// ===== verif/positional_list_insert_delete_search_core_test.sv =====
// testbench for the positional list core: random commands checked against a list predictor
`timescale 1ns / 100ps

module positional_list_insert_delete_search_core_test;
  import plids_pkg::*;

  // spare command codes that the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // run limits
  localparam int RANDOM_CMDS = 256;
  localparam int IDLE_LIMIT = 4000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  // list walk modes of the random part
  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } walk_mode_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    logic                    sync;
  } list_cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry;
    logic [OIDX_W-1:0]       index;
    status_e                 status;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // command [2:0], value [34:3], position [39:35]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // entry [31:0], index [36:32], status [38:37], length [44:39], zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  positional_list_insert_delete_search_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // predicted list contents and the results still owed by the block
  logic signed [VAL_W-1:0] list_store [DEPTH];
  int                      list_len = 0;
  list_result_t            expected_list_results [$];
  list_cmd_t               pending_cmds [$];

  int mismatches = 0;
  int cmds_taken = 0;

  // stimulus generator bookkeeping
  int                      gen_len = 0;
  logic signed [VAL_W-1:0] value_pool [8];
  int                      pool_wr = 0;

  function automatic void owe_result(logic signed [VAL_W-1:0] entry, int index,
                                     status_e status, logic last);
    list_result_t r;
    r.entry = entry;
    r.index = index[OIDX_W-1:0];
    r.status = status;
    r.length = list_len[LEN_W-1:0];
    r.last = last;
    expected_list_results.push_back(r);
  endfunction

  // list behavior for one accepted command
  function automatic void apply_list_command(list_cmd_t c);
    int i;
    int hit;
    hit = -1;
    case (c.cmd)
      CMD_CLEAR: begin
        list_len = 0;
        owe_result('0, 0, STAT_OK, 1'b1);
      end
      CMD_APPEND: begin
        if (list_len >= DEPTH) begin
          owe_result('0, 0, STAT_FULL, 1'b1);
        end else begin
          list_store[list_len] = c.value;
          list_len++;
          owe_result('0, 0, STAT_OK, 1'b1);
        end
      end
      CMD_INSERT: begin
        // full check wins over the position check
        if (list_len >= DEPTH) begin
          owe_result('0, 0, STAT_FULL, 1'b1);
        end else if (int'(c.pos) > list_len) begin
          owe_result('0, 0, STAT_RANGE, 1'b1);
        end else begin
          for (i = list_len; i > int'(c.pos); i--) list_store[i] = list_store[i-1];
          list_store[c.pos] = c.value;
          list_len++;
          owe_result('0, 0, STAT_OK, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (int'(c.pos) >= list_len) begin
          owe_result('0, 0, STAT_RANGE, 1'b1);
        end else begin
          for (i = c.pos; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
          owe_result('0, 0, STAT_OK, 1'b1);
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < list_len; i++)
          if (hit < 0 && list_store[i] == c.value) hit = i;
        if (hit < 0) owe_result('0, 0, STAT_MISSING, 1'b1);
        else owe_result('0, hit, STAT_OK, 1'b1);
      end
      CMD_DISPLAY: begin
        // an empty list still gives one closing result
        if (list_len == 0) owe_result('0, 0, STAT_OK, 1'b1);
        for (i = 0; i < list_len; i++)
          owe_result(list_store[i], i, STAT_OK, i + 1 == list_len);
      end
      default: owe_result('0, 0, STAT_OK, 1'b1);
    endcase
  endfunction

  // queue one command and track the list length it leaves behind
  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] value,
                                    logic [POS_W-1:0] pos, logic sync);
    list_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    c.pos = pos;
    c.sync = sync;
    pending_cmds.push_back(c);
    case (cmd)
      CMD_CLEAR: gen_len = 0;
      CMD_APPEND: if (gen_len < DEPTH) gen_len++;
      CMD_INSERT: if (gen_len < DEPTH && int'(pos) <= gen_len) gen_len++;
      CMD_DELETE: if (int'(pos) < gen_len) gen_len--;
      default: ;
    endcase
    if (cmd == CMD_APPEND || cmd == CMD_INSERT) begin
      value_pool[pool_wr % 8] = value;
      pool_wr++;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: return $signed($urandom_range(15)) - 8;
      default: return value_pool[$urandom_range(7)];
    endcase
  endfunction

  // any position, in range or not
  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] valid_insert_pos();
    return POS_W'($urandom_range(gen_len > 31 ? 31 : gen_len));
  endfunction

  function automatic logic [POS_W-1:0] valid_delete_pos();
    return gen_len > 0 ? POS_W'($urandom_range(gen_len - 1)) : '0;
  endfunction

  // directed opening, then random walks that fill and drain the list
  task automatic build_stimulus();
    walk_mode_e mode;
    int n;
    int r;
    logic sync;
    logic signed [VAL_W-1:0] key;
    mode = MODE_FILL;
    foreach (value_pool[i]) value_pool[i] = '0;

    // empty list corner cases
    queue_cmd(CMD_DISPLAY, 32'sd0, 5'd0, 1'b0);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd0, 1'b0);
    queue_cmd(CMD_SEARCH, 32'sd0, 5'd0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd7, 5'd1, 1'b0);
    // value extremes, insert at head and at the end
    queue_cmd(CMD_INSERT, 32'h7fffffff, 5'd0, 1'b0);
    queue_cmd(CMD_APPEND, 32'h80000000, 5'd31, 1'b0);
    queue_cmd(CMD_APPEND, -32'sd1, 5'd0, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd0, 5'd1, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd5, 5'd4, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd9, 5'd31, 1'b0);
    // searches: hit, duplicate keys give the first index, miss
    queue_cmd(CMD_SEARCH, 32'sd0, 5'd0, 1'b0);
    queue_cmd(CMD_APPEND, -32'sd1, 5'd0, 1'b0);
    queue_cmd(CMD_SEARCH, -32'sd1, 5'd31, 1'b0);
    queue_cmd(CMD_SEARCH, 32'h80000000, 5'd0, 1'b0);
    queue_cmd(CMD_SEARCH, 32'sd12345, 5'd0, 1'b0);
    // ignored codes
    queue_cmd(CMD_SPARE_A, 32'sd0, 5'd0, 1'b0);
    queue_cmd(CMD_SPARE_B, -32'sd1, 5'd31, 1'b0);
    // deletes out of range, at the head and at the tail
    queue_cmd(CMD_DELETE, 32'sd0, 5'd31, 1'b0);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd6, 1'b0);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd0, 1'b0);
    queue_cmd(CMD_DELETE, 32'sd0, 5'd4, 1'b0);
    queue_cmd(CMD_DISPLAY, 32'sd0, 5'd0, 1'b0);
    queue_cmd(CMD_CLEAR, -32'sd1, 5'd31, 1'b0);
    queue_cmd(CMD_DISPLAY, 32'sd0, 5'd0, 1'b0);

    for (n = 0; n < RANDOM_CMDS; n++) begin
      // switch walk mode at the ends of the list
      if (mode == MODE_FILL && gen_len == DEPTH && $urandom_range(3) == 0)
        mode = MODE_DRAIN;
      else if (mode == MODE_DRAIN && gen_len == 0)
        mode = $urandom_range(1) ? MODE_FILL : MODE_MIXED;
      else if (mode == MODE_MIXED && $urandom_range(39) == 0)
        mode = MODE_FILL;
      sync = (n == 90 || n == 190);
      key = $urandom_range(4) < 3 ? value_pool[$urandom_range(7)] : pick_value();
      r = $urandom_range(99);
      case (mode)
        MODE_FILL: begin
          if (r < 45) queue_cmd(CMD_APPEND, pick_value(), rand_pos(), sync);
          else if (r < 75) queue_cmd(CMD_INSERT, pick_value(), valid_insert_pos(), sync);
          else if (r < 85) queue_cmd(CMD_SEARCH, key, rand_pos(), sync);
          else if (r < 90) queue_cmd(CMD_DISPLAY, pick_value(), rand_pos(), sync);
          else if (r < 93) queue_cmd(CMD_INSERT, pick_value(), rand_pos(), sync);
          else if (r < 95) queue_cmd(CMD_DELETE, pick_value(), rand_pos(), sync);
          else if (r < 97) queue_cmd($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B,
                                     $urandom, rand_pos(), sync);
          else queue_cmd(CMD_SEARCH, pick_value(), rand_pos(), sync);
        end
        MODE_DRAIN: begin
          if (r < 55) queue_cmd(CMD_DELETE, pick_value(), valid_delete_pos(), sync);
          else if (r < 65) queue_cmd(CMD_DELETE, pick_value(), rand_pos(), sync);
          else if (r < 80) queue_cmd(CMD_SEARCH, key, rand_pos(), sync);
          else if (r < 85) queue_cmd(CMD_DISPLAY, pick_value(), rand_pos(), sync);
          else if (r < 92) queue_cmd(CMD_APPEND, pick_value(), rand_pos(), sync);
          else if (r < 95) queue_cmd($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B,
                                     $urandom, rand_pos(), sync);
          else queue_cmd(CMD_CLEAR, pick_value(), rand_pos(), sync);
        end
        default: begin
          if (r < 25) queue_cmd(CMD_APPEND, pick_value(), rand_pos(), sync);
          else if (r < 45) queue_cmd(CMD_INSERT, pick_value(), valid_insert_pos(), sync);
          else if (r < 65) queue_cmd(CMD_DELETE, pick_value(), valid_delete_pos(), sync);
          else if (r < 80) queue_cmd(CMD_SEARCH, key, rand_pos(), sync);
          else if (r < 88) queue_cmd(CMD_DISPLAY, pick_value(), rand_pos(), sync);
          else if (r < 93) queue_cmd($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B,
                                     $urandom, rand_pos(), sync);
          else if (r < 96) queue_cmd($urandom_range(1) ? CMD_INSERT : CMD_DELETE,
                                     pick_value(), rand_pos(), sync);
          else queue_cmd(CMD_CLEAR, pick_value(), rand_pos(), sync);
        end
      endcase
    end
  endtask

  // command driver: bursts with random gaps, pauses on sync points
  list_cmd_t cur_cmd = '0;
  int        burst_left = 0;
  int        gap_left = 0;
  logic      offer;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_list_command(cur_cmd);
        cmds_taken++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].sync && expected_list_results.size() > 0)) begin
          cur_cmd = pending_cmds.pop_front();
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(2) == 0 ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_axis_tvalid <= offer;
      s_axis_tdata <= {cur_cmd.pos, cur_cmd.value, cur_cmd.cmd};
    end
  end

  // result receiver: changing stall modes plus one long hold-off
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  logic [31:0] rx_pattern = '0;
  int          holdoff_left = 0;
  logic        holdoff_done = 1'b0;
  logic        rdy;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(2);
        rx_mode_left = $urandom_range(16, 96);
        rx_pattern = $urandom;
      end else begin
        rx_mode_left--;
      end
      if (!holdoff_done && cmds_taken >= 40) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(1));
          default: begin
            rdy = rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
          end
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // result checker
  list_result_t got;
  list_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.entry = m_axis_tdata[31:0];
      got.index = m_axis_tdata[36:32];
      got.status = status_e'(m_axis_tdata[38:37]);
      got.length = m_axis_tdata[44:39];
      got.last = m_axis_tlast;
      if (expected_list_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: entry %0d index %0d status %0d length %0d last %0d",
                   got.entry, got.index, got.status, got.length, got.last);
      end else begin
        want = expected_list_results.pop_front();
        if (got.entry !== want.entry || got.index !== want.index ||
            got.status !== want.status || got.length !== want.length ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp entry %0d index %0d status %0d length %0d last %0d,",
                      " got entry %0d index %0d status %0d length %0d last %0d"},
                     want.entry, want.index, want.status, want.length, want.last,
                     got.entry, got.index, got.status, got.length, got.last);
        end
      end
    end
  end

  // watchdog on stalled handshakes and on total run length
  int idle_cycles = 0;
  int run_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      run_cycles++;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT || run_cycles >= CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_cmds.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_list_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_list_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/plids_pkg.sv
src/plids_ctrl.sv
src/plids_dp.sv
src/positional_list_insert_delete_search_core.sv
verif/positional_list_insert_delete_search_core_test.sv
